@@ src/msld_pkg.sv @@
`timescale 1ns / 1ps

package msld_pkg;

    localparam int HEADER_BYTES     = 16;
    localparam int TRAILER_BYTES    = 4;
    localparam int MAGIC_BYTES      = 4;
    localparam int LENGTH_FIELD_POS = 12;
    localparam int MIN_LENGTH       = HEADER_BYTES + TRAILER_BYTES + 1;

    localparam logic [31:0] MAGIC_WORD = 32'h4448_4156;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_BAD = 2'd2,
        KIND_BAD_LEN = 2'd3
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] packet_length;
    } t_result;

endpackage

@@ src/msld_if.sv @@
`timescale 1ns / 1ps

interface msld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface msld_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] packet_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output packet_length, input ready);
    modport sink (input valid, input result_kind, input payload_byte,
                  input packet_length, output ready);
endinterface

@@ src/msld_parser.sv @@
`timescale 1ns / 1ps

module msld_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output msld_pkg::t_result o_result
);
    import msld_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_recent, n_recent;
    logic [31:0] r_idx, n_idx;
    logic [31:0] r_len, n_len;
    logic [31:0] r_trailer, n_trailer;
    t_result     n_result;

    always_comb begin
        n_phase   = r_phase;
        n_recent  = r_recent;
        n_idx     = r_idx;
        n_len     = r_len;
        n_trailer = r_trailer;
        n_result  = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_idx >= 32'(LENGTH_FIELD_POS)) begin
                    n_len = r_len | (32'(i_byte) << {r_idx[1:0], 3'b000});
                end
                if (r_idx >= 32'(HEADER_BYTES - 1)) begin
                    if (n_len < 32'(MIN_LENGTH)) begin
                        n_result.valid         = 1'b1;
                        n_result.kind          = KIND_BAD_LEN;
                        n_result.packet_length = n_len;
                        n_phase                = PH_HUNT;
                        n_recent               = '0;
                        n_idx                  = '0;
                    end else begin
                        n_phase   = PH_BODY;
                        n_idx     = 32'(HEADER_BYTES);
                        n_trailer = '0;
                    end
                end else begin
                    n_idx = r_idx + 32'd1;
                end
            end
            PH_BODY: begin
                if (r_idx < r_len - 32'(TRAILER_BYTES)) begin
                    n_result.valid        = 1'b1;
                    n_result.kind         = KIND_PAYLOAD;
                    n_result.payload_byte = i_byte;
                    n_idx                 = r_idx + 32'd1;
                end else begin
                    n_trailer = {i_byte, r_trailer[31:8]};
                    if (r_idx >= r_len - 32'd1) begin
                        n_result.valid         = 1'b1;
                        n_result.kind          = (n_trailer == r_len) ? KIND_END_OK
                                                                      : KIND_END_BAD;
                        n_result.packet_length = r_len;
                        n_phase                = PH_HUNT;
                        n_recent               = '0;
                        n_idx                  = '0;
                    end else begin
                        n_idx = r_idx + 32'd1;
                    end
                end
            end
            default: begin
                n_recent = {r_recent[23:0], i_byte};
                if (n_recent == MAGIC_WORD) begin
                    n_phase  = PH_HEADER;
                    n_idx    = 32'(MAGIC_BYTES);
                    n_len    = '0;
                    n_recent = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_recent  <= '0;
            r_idx     <= '0;
            r_len     <= '0;
            r_trailer <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_recent  <= n_recent;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_trailer <= n_trailer;
        end
    end

    assign o_result = n_result;

endmodule

@@ src/magic_sync_length_deframer.sv @@
`timescale 1ns / 1ps

// Channel    Port      Direction  Word
// ---------  --------  ---------  -------------------------------------------
// stream     i_byte    in         stream_byte
// results    o_result  out        result_kind, payload_byte, packet_length
//
// One byte is taken every cycle while the result side keeps up.
// A byte passes an input register, then the parser updates its state and
// loads the result register.
// Reset returns the parser to the magic search with an empty window.
// A stalled result holds the result register; one more byte waits in the
// input register before the stream side sees ready drop.

module magic_sync_length_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    msld_byte_if.sink            i_byte,
    msld_result_if.source        o_result
);
    import msld_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_result    r_out;
    t_result    parser_result;
    logic       step;

    assign step         = r_in_valid && (!r_out.valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || step;

    msld_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (parser_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (step) begin
            r_out <= parser_result;
        end else if (o_result.ready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_result.valid         = r_out.valid;
    assign o_result.result_kind   = r_out.kind;
    assign o_result.payload_byte  = r_out.payload_byte;
    assign o_result.packet_length = r_out.packet_length;

endmodule

@@ bench/msld_frame_checker.sv @@
`timescale 1ns / 1ps

module msld_frame_checker
    import msld_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    msld_byte_if   i_byte,
    msld_result_if i_result,
    output int     o_pending,
    output int     o_checked,
    output int     o_fail_count
);

    typedef enum logic [1:0] {
        SCAN_HUNT   = 2'd0,
        SCAN_HEADER = 2'd1,
        SCAN_BODY   = 2'd2
    } t_scan_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] packet_length;
    } t_frame_result;

    t_scan_phase   scan_phase;
    logic [31:0]   sync_window;
    logic [31:0]   frame_index;
    logic [31:0]   frame_length;
    logic [31:0]   trailer_acc;
    t_frame_result expected_results[$];
    int            checked_total;
    int            fail_total;

    function automatic bit parse_stream_byte(input logic [7:0] b, output t_frame_result res);
        logic [31:0] shift;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.packet_length = 32'd0;
        parse_stream_byte = 1'b0;
        case (scan_phase)
            SCAN_HEADER: begin
                if (frame_index >= 32'(LENGTH_FIELD_POS)) begin
                    shift = ((frame_index - 32'(LENGTH_FIELD_POS)) & 32'd3) * 32'd8;
                    frame_length = frame_length | (32'(b) << shift);
                end
                if (frame_index >= 32'(HEADER_BYTES - 1)) begin
                    if (frame_length < 32'(MIN_LENGTH)) begin
                        res.kind = KIND_BAD_LEN;
                        res.packet_length = frame_length;
                        parse_stream_byte = 1'b1;
                        scan_phase = SCAN_HUNT;
                        sync_window = 32'd0;
                        frame_index = 32'd0;
                    end else begin
                        scan_phase = SCAN_BODY;
                        frame_index = 32'(HEADER_BYTES);
                        trailer_acc = 32'd0;
                    end
                end else begin
                    frame_index = frame_index + 32'd1;
                end
            end
            SCAN_BODY: begin
                if (frame_index < frame_length - 32'(TRAILER_BYTES)) begin
                    res.payload_byte = b;
                    parse_stream_byte = 1'b1;
                    frame_index = frame_index + 32'd1;
                end else begin
                    trailer_acc = {b, trailer_acc[31:8]};
                    if (frame_index >= frame_length - 32'd1) begin
                        res.kind = (trailer_acc == frame_length) ? KIND_END_OK : KIND_END_BAD;
                        res.packet_length = frame_length;
                        parse_stream_byte = 1'b1;
                        scan_phase = SCAN_HUNT;
                        sync_window = 32'd0;
                        frame_index = 32'd0;
                    end else begin
                        frame_index = frame_index + 32'd1;
                    end
                end
            end
            default: begin
                sync_window = {sync_window[23:0], b};
                if (sync_window == MAGIC_WORD) begin
                    scan_phase = SCAN_HEADER;
                    frame_index = 32'(MAGIC_BYTES);
                    frame_length = 32'd0;
                    sync_window = 32'd0;
                end else begin
                    scan_phase = SCAN_HUNT;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame_result got;
        t_frame_result want;
        if (!i_rst_n) begin
            scan_phase = SCAN_HUNT;
            sync_window = 32'd0;
            frame_index = 32'd0;
            frame_length = 32'd0;
            trailer_acc = 32'd0;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.kind = t_kind'(i_result.result_kind);
                got.payload_byte = i_result.payload_byte;
                got.packet_length = i_result.packet_length;
                if (expected_results.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("Unexpected result: kind %0d byte %02h length %0d",
                                 got.kind, got.payload_byte, got.packet_length);
                    end
                    fail_total++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    checked_total++;
                    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte
                            || got.packet_length !== want.packet_length) begin
                        if (fail_total < 10) begin
                            $display({"Mismatch on result %0d: expected kind %0d byte %02h",
                                      " length %0d, got kind %0d byte %02h length %0d"},
                                     checked_total, want.kind, want.payload_byte,
                                     want.packet_length, got.kind, got.payload_byte,
                                     got.packet_length);
                        end
                        fail_total++;
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                if (parse_stream_byte(i_byte.stream_byte, want)) begin
                    expected_results.push_back(want);
                end
            end
        end
        o_pending <= expected_results.size();
        o_checked <= checked_total;
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import msld_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int FRAME_BYTE_GOAL  = 1400;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_TEST_LENGTH  = 64;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   checked;
    int   fail_count;
    int   cycle_count;
    int   bytes_sent;
    int   frame_bytes;
    int   frames_ok;
    int   frames_bad_trailer;
    int   frames_short;
    bit   hold_req;
    bit   quiet;

    msld_byte_if   byte_ch ();
    msld_result_if res_ch ();

    magic_sync_length_deframer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch)
    );

    msld_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_result     (res_ch),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("testbench failed");
            $finish;
        end
    end

    // The result side stalls in short bursts and, once, for a long stretch.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        byte_ch.valid <= 1'b1;
        byte_ch.stream_byte <= value;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_word_le(input logic [31:0] word);
        for (int k = 0; k < 4; k++) send_byte(word[8*k +: 8]);
    endtask

    task automatic send_header(input logic [31:0] length);
        for (int k = MAGIC_BYTES - 1; k >= 0; k--) send_byte(MAGIC_WORD[8*k +: 8]);
        repeat (LENGTH_FIELD_POS - MAGIC_BYTES) send_byte(8'($urandom));
        send_word_le(length);
    endtask

    task automatic send_payload(input int count);
        repeat (count) send_byte(8'($urandom));
    endtask

    initial begin : stimulus
        int          pick;
        int          count;
        bit          paused;
        bit          held;
        logic [31:0] length;
        logic [31:0] trailer;
        byte_ch.valid <= 1'b0;
        byte_ch.stream_byte <= 8'd0;
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(32'(MIN_LENGTH - 1));
        frames_short++;
        for (int k = MAGIC_BYTES - 1; k >= 1; k--) send_byte(MAGIC_WORD[8*k +: 8]);
        send_byte(MAGIC_WORD[31:24]);

        while (frame_bytes < FRAME_BYTE_GOAL) begin
            if (!held && frame_bytes >= 450) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && frame_bytes >= 900) begin
                paused = 1'b1;
                byte_ch.valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            if (frame_bytes >= 1200) begin
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                length = 32'($urandom_range(MIN_LENGTH, MAX_TEST_LENGTH));
                trailer = length;
                if ($urandom_range(0, 4) == 0) begin
                    trailer = length ^ (32'd1 << $urandom_range(0, 31));
                    frames_bad_trailer++;
                end else begin
                    frames_ok++;
                end
                send_header(length);
                send_payload(int'(length) - HEADER_BYTES - TRAILER_BYTES);
                send_word_le(trailer);
                frame_bytes += int'(length);
            end else if (pick < 72) begin
                send_header(32'($urandom_range(0, MIN_LENGTH - 1)));
                frames_short++;
                frame_bytes += HEADER_BYTES;
            end else if (pick < 86) begin
                send_payload($urandom_range(1, 6));
            end else begin
                count = $urandom_range(1, 3);
                for (int k = 0; k < count; k++) send_byte(MAGIC_WORD[8*(3-k) +: 8]);
                send_byte(8'($urandom));
            end
        end

        // A frame too long to ever finish exercises the upper length bits.
        send_header(32'hFFFF_FFFF);
        send_payload(40);
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d stream words: %0d good frames, %0d corrupt trailers, %0d short%s",
                 bytes_sent, frames_ok, frames_bad_trailer, frames_short, " lengths.");
        $display("Checked %0d results with %0d failures.", checked, fail_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
